// ----- sv/wtc_pkg.sv -----
// wtc_pkg: shared types, constants and word tables of the word token classifier
// depends on nothing; imported by the interfaces and every module of the block
package wtc_pkg;

  // field widths
  localparam int CHAR_W     = 8;
  localparam int POS_W      = 32;
  localparam int LEN_W      = 16;
  localparam int CLASS_W    = 3;
  localparam int CODE_W     = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  // word buffer geometry (supported range 11 to 16)
  localparam int MAX_WORD_CHARS = 11;
  localparam int WIDX_W         = $clog2(MAX_WORD_CHARS);

  // queue between the scanner and the classifier
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TERM_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TERM_HIGH = CFG_IDX_W'(1);

  // token classes
  localparam logic [CLASS_W-1:0] CLS_ILLEGAL = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_INTEGER = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_FLOAT   = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_BOOLEAN = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_KEYWORD = 3'd4;
  localparam logic [CLASS_W-1:0] CLS_TYPE    = 3'd5;
  localparam logic [CLASS_W-1:0] CLS_IDENT   = 3'd6;
  localparam logic [CLASS_W-1:0] CLS_EOF     = 3'd7;

  // special characters
  localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2e;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

  // word tables: text right-aligned, last character in the low byte
  localparam int TEXT_W       = 128;
  localparam int NUM_KEYWORDS = 16;
  localparam int NUM_TYPES    = 13;

  localparam logic [TEXT_W-1:0] KW_TEXT [NUM_KEYWORDS] = '{
    "ret", "brk", "for", "while", "do", "if", "elif", "else",
    "cont", "struct", "enum", "switch", "case", "default", "fallthrough", "namespace"
  };
  localparam int KW_LEN [NUM_KEYWORDS] = '{
    3, 3, 3, 5, 2, 2, 4, 4, 4, 6, 4, 6, 4, 7, 11, 9
  };

  localparam logic [TEXT_W-1:0] TY_TEXT [NUM_TYPES] = '{
    "u8", "i8", "u16", "i16", "u32", "i32", "u64", "i64", "f32", "f64",
    "proc", "bool", "void"
  };
  localparam int TY_LEN [NUM_TYPES] = '{
    2, 2, 3, 3, 3, 3, 3, 3, 3, 3, 4, 4, 4
  };

  localparam logic [TEXT_W-1:0] TRUE_TEXT  = "true";
  localparam int                TRUE_LEN   = 4;
  localparam logic [TEXT_W-1:0] FALSE_TEXT = "false";
  localparam int                FALSE_LEN  = 5;

  typedef logic [MAX_WORD_CHARS-1:0][CHAR_W-1:0] word_buf_t;

  // one finished token as the scanner hands it on
  typedef struct packed {
    logic                 is_word;
    logic [CLASS_W-1:0]   cls;
    logic [POS_W-1:0]     start;
    logic [LEN_W-1:0]     length;
    word_buf_t            wbuf;
  } token_desc_t;

endpackage

// ----- sv/wtc_if.sv -----
// wtc_if: valid/ready channel interfaces of the word token classifier
// depends on wtc_pkg for the field widths
interface wtc_in_if;
  import wtc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic [POS_W-1:0]  position;
  modport source (output valid, output character, output position, input ready);
  modport sink (input valid, input character, input position, output ready);
endinterface

interface wtc_out_if;
  import wtc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] token_class;
  logic [CODE_W-1:0]  word_code;
  logic [POS_W-1:0]   start_position;
  logic [LEN_W-1:0]   token_length;
  logic               consumed;
  modport source (output valid, output token_class, output word_code,
                  output start_position, output token_length, output consumed,
                  input ready);
  modport sink (input valid, input token_class, input word_code,
                input start_position, input token_length, input consumed,
                output ready);
endinterface

interface wtc_cfg_if;
  import wtc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- sv/wtc_front.sv -----
// wtc_front: character scanner; holds the terminator masks and the token state
// depends on wtc_pkg and wtc_if; pushes finished tokens into wtc_queue
module wtc_front (
  input  logic                clk,
  input  logic                rst_n,
  wtc_in_if.sink              in_chan,
  wtc_cfg_if.sink             cfg_chan,
  input  logic                q_full,
  output logic                q_push,
  output wtc_pkg::token_desc_t q_desc
);
  import wtc_pkg::*;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_NUMBER = 2'd1;
  localparam logic [1:0] MODE_WORD   = 2'd2;

  logic [CFG_DATA_W-1:0] mask_lo_r, mask_hi_r;
  logic [1:0]            mode_r, mode_nxt;
  logic [POS_W-1:0]      start_r, start_nxt;
  logic [LEN_W-1:0]      count_r, count_nxt, count_inc;
  logic                  dot_r, dot_nxt;
  logic                  ldot_r, ldot_nxt;
  logic                  bad_r, bad_nxt;
  word_buf_t             wbuf_r, wbuf_nxt;
  logic                  accept, is_term, is_dig;
  logic [CHAR_W-1:0]     c;

  assign in_chan.ready  = !q_full;
  assign cfg_chan.ready = 1'b1;

  // terminator masks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_lo_r <= '0;
      mask_hi_r <= '0;
    end else if (cfg_chan.valid) begin
      if (cfg_chan.reg_index == REG_TERM_LOW) mask_lo_r <= cfg_chan.wdata;
      if (cfg_chan.reg_index == REG_TERM_HIGH) mask_hi_r <= cfg_chan.wdata;
    end
  end

  // scan step for one character beat
  always_comb begin
    c         = in_chan.character;
    accept    = in_chan.valid && !q_full;
    is_term   = c[7] ? 1'b0 : (c[6] ? mask_hi_r[c[5:0]] : mask_lo_r[c[5:0]]);
    is_dig    = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    count_inc = (count_r == '1) ? count_r : count_r + LEN_W'(1);

    mode_nxt  = mode_r;
    start_nxt = start_r;
    count_nxt = count_r;
    dot_nxt   = dot_r;
    ldot_nxt  = ldot_r;
    bad_nxt   = bad_r;
    wbuf_nxt  = wbuf_r;

    q_push         = 1'b0;
    q_desc.is_word = 1'b0;
    q_desc.cls     = CLS_ILLEGAL;
    q_desc.start   = start_r;
    q_desc.length  = count_r;
    q_desc.wbuf    = wbuf_r;

    if (accept) begin
      unique case (mode_r)
        MODE_NUMBER: begin
          if (c == CHAR_NUL || (is_term && c != CHAR_DOT)) begin
            q_push     = 1'b1;
            q_desc.cls = (bad_r || ldot_r) ? CLS_ILLEGAL :
                         (dot_r ? CLS_FLOAT : CLS_INTEGER);
            mode_nxt   = MODE_IDLE;
          end else begin
            if (c == CHAR_DOT) begin
              bad_nxt  = bad_r | dot_r;
              dot_nxt  = 1'b1;
              ldot_nxt = 1'b1;
            end else begin
              bad_nxt  = bad_r | !is_dig;
              ldot_nxt = 1'b0;
            end
            count_nxt = count_inc;
          end
        end
        MODE_WORD: begin
          if (c == CHAR_NUL || is_term) begin
            q_push         = 1'b1;
            q_desc.is_word = 1'b1;
            mode_nxt       = MODE_IDLE;
          end else begin
            if (count_r < LEN_W'(MAX_WORD_CHARS)) wbuf_nxt[count_r[WIDX_W-1:0]] = c;
            count_nxt = count_inc;
          end
        end
        default: begin
          // idle, and the unused mode code
          priority if (c == CHAR_NUL) begin
            q_push        = 1'b1;
            q_desc.cls    = CLS_EOF;
            q_desc.start  = in_chan.position - POS_W'(1);
            q_desc.length = '0;
          end else if (is_term) begin
            q_push        = 1'b1;
            q_desc.cls    = CLS_ILLEGAL;
            q_desc.start  = in_chan.position;
            q_desc.length = '0;
          end else begin
            start_nxt = in_chan.position;
            count_nxt = LEN_W'(1);
            dot_nxt   = 1'b0;
            ldot_nxt  = 1'b0;
            bad_nxt   = 1'b0;
            if (is_dig) begin
              mode_nxt = MODE_NUMBER;
            end else begin
              mode_nxt    = MODE_WORD;
              wbuf_nxt[0] = c;
            end
          end
        end
      endcase
    end
  end

  // token state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      start_r <= '0;
      count_r <= '0;
      dot_r   <= 1'b0;
      ldot_r  <= 1'b0;
      bad_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      count_r <= count_nxt;
      dot_r   <= dot_nxt;
      ldot_r  <= ldot_nxt;
      bad_r   <= bad_nxt;
    end
  end

  // word characters, no reset
  always_ff @(posedge clk) begin
    wbuf_r <= wbuf_nxt;
  end

endmodule

// ----- sv/wtc_queue.sv -----
// wtc_queue: short token queue between scanner and classifier
// depends on wtc_pkg for the token descriptor and the depth
module wtc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  wtc_pkg::token_desc_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output wtc_pkg::token_desc_t pop_data
);
  import wtc_pkg::*;

  token_desc_t       slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] fill_r;
  logic              do_push, do_pop;

  assign full      = (fill_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (fill_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      if (do_push && !do_pop) fill_r <= fill_r + QCNT_W'(1);
      else if (do_pop && !do_push) fill_r <= fill_r - QCNT_W'(1);
    end
  end

endmodule

// ----- sv/wtc_back.sv -----
// wtc_back: word matcher and result register of the classifier
// depends on wtc_pkg for the word tables and wtc_if for the result channel
module wtc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  wtc_pkg::token_desc_t q_data,
  output logic                 q_pop,
  wtc_out_if.source            out_chan
);
  import wtc_pkg::*;

  logic               out_valid_r;
  logic [CLASS_W-1:0] cls_r, cls_nxt;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic [POS_W-1:0]   start_r;
  logic [LEN_W-1:0]   len_r;

  // fixed-string compare of the buffered word against one table entry
  function automatic logic word_is(word_buf_t b, logic [LEN_W-1:0] n,
                                   logic [TEXT_W-1:0] text, int len);
    logic eq;
    eq = (n == LEN_W'(len)) && (len <= MAX_WORD_CHARS);
    for (int j = 0; j < MAX_WORD_CHARS; j++) begin
      if (j < len) begin
        if (b[j] != text[CHAR_W*(len-1-j) +: CHAR_W]) eq = 1'b0;
      end
    end
    return eq;
  endfunction

  // class and code; later checks take priority
  always_comb begin
    cls_nxt  = q_data.cls;
    code_nxt = '0;
    if (q_data.is_word) begin
      cls_nxt = CLS_IDENT;
      for (int i = NUM_TYPES - 1; i >= 0; i--) begin
        if (word_is(q_data.wbuf, q_data.length, TY_TEXT[i], TY_LEN[i])) begin
          cls_nxt  = CLS_TYPE;
          code_nxt = CODE_W'(i);
        end
      end
      for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
        if (word_is(q_data.wbuf, q_data.length, KW_TEXT[i], KW_LEN[i])) begin
          cls_nxt  = CLS_KEYWORD;
          code_nxt = CODE_W'(i);
        end
      end
      if (word_is(q_data.wbuf, q_data.length, FALSE_TEXT, FALSE_LEN)) begin
        cls_nxt  = CLS_BOOLEAN;
        code_nxt = '0;
      end
      if (word_is(q_data.wbuf, q_data.length, TRUE_TEXT, TRUE_LEN)) begin
        cls_nxt  = CLS_BOOLEAN;
        code_nxt = CODE_W'(1);
      end
    end
  end

  assign q_pop = q_valid && (!out_valid_r || out_chan.ready);

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_chan.ready) begin
      out_valid_r <= q_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cls_r   <= cls_nxt;
      code_r  <= code_nxt;
      start_r <= q_data.start;
      len_r   <= q_data.length;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.token_class    = cls_r;
  assign out_chan.word_code      = code_r;
  assign out_chan.start_position = start_r;
  assign out_chan.token_length   = len_r;
  assign out_chan.consumed       = 1'b0;

endmodule

// ----- sv/word_token_classifier.sv -----
// word_token_classifier: top level, scanner, token queue and classifier
// depends on wtc_pkg, wtc_if, wtc_front, wtc_queue and wtc_back
//
// Usage:
//  in_chan carries one source character and its offset per beat; a 0
//  character ends the source and, between tokens, yields an end-of-file
//  result. The character that ends a token is not part of it: the sender
//  presents it again as the next beat.
//  out_chan carries one token per beat: class, word code, start offset,
//  length (saturating at 65535) and a consumed flag that is always 0.
//  cfg_chan writes the two 64-bit terminator masks and is always ready. The
//  user must write it only while no token is in flight; nothing enforces it.
// Timing:
//  one character per cycle, sustained while the token queue is not full; the
//  scanner state updates every beat. A token passes through the token queue
//  and then the result register on its way to out_chan.
//  When out_chan stalls, up to two tokens wait in the queue; in_chan drops
//  ready only once the queue is full.
// Reset:
//  synchronous, active low; clears masks, scan state, queue and result valid.
module word_token_classifier (
  input  logic      clk,
  input  logic      rst_n,
  wtc_in_if.sink    in_chan,
  wtc_out_if.source out_chan,
  wtc_cfg_if.sink   cfg_chan
);
  import wtc_pkg::*;

  token_desc_t push_desc, pop_desc;
  logic        q_push, q_full, q_pop, q_valid;

  wtc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_desc   (push_desc)
  );

  wtc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (pop_desc)
  );

  wtc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (pop_desc),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

// ----- sv/wtc_checker.sv -----
// wtc_checker: port-level assertions on the result channel, bound to the top
// depends on wtc_pkg for the class codes and field widths
module wtc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [wtc_pkg::CLASS_W-1:0] out_class,
  input logic [wtc_pkg::CODE_W-1:0]  out_code,
  input logic [wtc_pkg::LEN_W-1:0]   out_length,
  input logic                        out_consumed
);
  import wtc_pkg::*;

  // nothing is offered in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // the ending character never belongs to the token
  a_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_consumed)
    else $error("result marks its character consumed");

  // end of file is empty and carries no word code
  a_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_class == CLS_EOF |-> out_length == '0 && out_code == '0)
    else $error("end-of-file result with length or code");

  // only keyword, type and boolean results carry a word code
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_code != '0 |->
      out_class == CLS_KEYWORD || out_class == CLS_TYPE ||
      (out_class == CLS_BOOLEAN && out_code == CODE_W'(1)))
    else $error("word code on a class that has none");

endmodule

bind word_token_classifier wtc_checker u_wtc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_class    (out_chan.token_class),
  .out_code     (out_chan.word_code),
  .out_length   (out_chan.token_length),
  .out_consumed (out_chan.consumed)
);

// ----- tb/sv/word_token_classifier_checker.sv -----
// word_token_classifier_checker: watches the character, token and register channels,
// predicts every token from its own scanner model and compares field by field
// depends on wtc_pkg for widths, classes, special characters and word tables, and on wtc_if
module word_token_classifier_checker (
  input  logic clk,
  input  logic rst_n,
  wtc_in_if    in_mon,
  wtc_out_if   out_mon,
  wtc_cfg_if   cfg_mon,
  output int   mismatches,
  output int   awaited
);
  import wtc_pkg::*;

  localparam int REPORT_LIMIT = 10;
  localparam logic [CODE_W-1:0] CODE_FALSE = CODE_W'(0);
  localparam logic [CODE_W-1:0] CODE_TRUE  = CODE_W'(1);

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUMBER, SCAN_WORD} scan_mode_t;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [CODE_W-1:0]  code;
    logic [POS_W-1:0]   start_pos;
    logic [LEN_W-1:0]   length;
    logic               used;
  } token_rec_t;

  // scanner model state
  logic [CFG_DATA_W-1:0] term_lo, term_hi;
  scan_mode_t            mode;
  logic [POS_W-1:0]      tok_start;
  logic [LEN_W-1:0]      tok_len;
  logic                  dot_seen, prev_dot, num_bad;
  logic [CHAR_W-1:0]     word_chars [MAX_WORD_CHARS];

  token_rec_t token_queue [$];
  int         fail_total;

  function automatic logic ends_token(input logic [CHAR_W-1:0] c);
    if (c < 64) return term_lo[c[5:0]];
    if (c < 128) return term_hi[c[5:0]];
    return 1'b0;
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  function automatic void grow_len();
    if (tok_len != '1) tok_len++;
  endfunction

  function automatic token_rec_t make_rec(input logic [CLASS_W-1:0] cls,
                                          input logic [CODE_W-1:0] code,
                                          input logic [POS_W-1:0] start_pos,
                                          input logic [LEN_W-1:0] length);
    token_rec_t rec;
    rec.cls       = cls;
    rec.code      = code;
    rec.start_pos = start_pos;
    rec.length    = length;
    rec.used      = 1'b0;
    mode          = SCAN_IDLE;
    return rec;
  endfunction

  // word lookup: booleans first, then keywords, then type names
  function automatic token_rec_t classify_word();
    logic [TEXT_W-1:0] text;
    text = '0;
    if (tok_len <= MAX_WORD_CHARS)
      for (int i = 0; i < int'(tok_len); i++)
        text = {text[TEXT_W-CHAR_W-1:0], word_chars[i]};
    if (tok_len == TRUE_LEN && text == TRUE_TEXT)
      return make_rec(CLS_BOOLEAN, CODE_TRUE, tok_start, tok_len);
    if (tok_len == FALSE_LEN && text == FALSE_TEXT)
      return make_rec(CLS_BOOLEAN, CODE_FALSE, tok_start, tok_len);
    for (int k = 0; k < NUM_KEYWORDS; k++)
      if (tok_len == KW_LEN[k] && text == KW_TEXT[k])
        return make_rec(CLS_KEYWORD, CODE_W'(k), tok_start, tok_len);
    for (int k = 0; k < NUM_TYPES; k++)
      if (tok_len == TY_LEN[k] && text == TY_TEXT[k])
        return make_rec(CLS_TYPE, CODE_W'(k), tok_start, tok_len);
    return make_rec(CLS_IDENT, '0, tok_start, tok_len);
  endfunction

  // one character beat; returns 1 when it finishes a token
  function automatic logic scan_char(input logic [CHAR_W-1:0] c, input logic [POS_W-1:0] p,
                                     output token_rec_t rec);
    logic [CLASS_W-1:0] cls;
    case (mode)
      SCAN_NUMBER: begin
        if (c == CHAR_NUL || (ends_token(c) && c != CHAR_DOT)) begin
          if (num_bad || prev_dot) cls = CLS_ILLEGAL;
          else cls = dot_seen ? CLS_FLOAT : CLS_INTEGER;
          rec = make_rec(cls, '0, tok_start, tok_len);
          return 1'b1;
        end
        if (c == CHAR_DOT) begin
          if (dot_seen) num_bad = 1'b1;
          dot_seen = 1'b1;
          prev_dot = 1'b1;
        end else begin
          if (!is_digit(c)) num_bad = 1'b1;
          prev_dot = 1'b0;
        end
        grow_len();
        return 1'b0;
      end
      SCAN_WORD: begin
        if (c == CHAR_NUL || ends_token(c)) begin
          rec = classify_word();
          return 1'b1;
        end
        if (tok_len < MAX_WORD_CHARS) word_chars[tok_len[WIDX_W-1:0]] = c;
        grow_len();
        return 1'b0;
      end
      default: begin
        // between tokens: end of source, empty token, or the first character
        if (c == CHAR_NUL) begin
          rec = make_rec(CLS_EOF, '0, p - POS_W'(1), '0);
          return 1'b1;
        end
        if (ends_token(c)) begin
          rec = make_rec(CLS_ILLEGAL, '0, p, '0);
          return 1'b1;
        end
        tok_start = p;
        tok_len   = LEN_W'(1);
        dot_seen  = 1'b0;
        prev_dot  = 1'b0;
        num_bad   = 1'b0;
        if (is_digit(c)) begin
          mode = SCAN_NUMBER;
        end else begin
          mode          = SCAN_WORD;
          word_chars[0] = c;
        end
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void log_failure(input string what, input token_rec_t want,
                                      input token_rec_t got);
    string want_txt;
    string got_txt;
    fail_total++;
    if (fail_total <= REPORT_LIMIT) begin
      want_txt = $sformatf("class %0d code %0d start %h length %0d consumed %0d",
                           want.cls, want.code, want.start_pos, want.length, want.used);
      got_txt  = $sformatf("class %0d code %0d start %h length %0d consumed %0d",
                           got.cls, got.code, got.start_pos, got.length, got.used);
      $display("%0t %s: expected %s, got %s", $time, what, want_txt, got_txt);
    end
  endfunction

  always @(posedge clk) begin
    token_rec_t got;
    token_rec_t want;
    token_rec_t fresh;
    if (!rst_n) begin
      term_lo    = '0;
      term_hi    = '0;
      mode       = SCAN_IDLE;
      tok_start  = '0;
      tok_len    = '0;
      dot_seen   = 1'b0;
      prev_dot   = 1'b0;
      num_bad    = 1'b0;
      fail_total = 0;
      token_queue.delete();
    end else begin
      // register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.reg_index == REG_TERM_LOW) term_lo = cfg_mon.wdata;
        else if (cfg_mon.reg_index == REG_TERM_HIGH) term_hi = cfg_mon.wdata;
      end
      // token beat against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got.cls       = out_mon.token_class;
        got.code      = out_mon.word_code;
        got.start_pos = out_mon.start_position;
        got.length    = out_mon.token_length;
        got.used      = out_mon.consumed;
        if (token_queue.size() == 0) begin
          log_failure("token with none awaited", got, got);
        end else begin
          want = token_queue.pop_front();
          if (got.cls !== want.cls || got.code !== want.code ||
              got.start_pos !== want.start_pos || got.length !== want.length ||
              got.used !== want.used)
            log_failure("token differs", want, got);
        end
      end
      // character beat
      if (in_mon.valid && in_mon.ready)
        if (scan_char(in_mon.character, in_mon.position, fresh)) token_queue.push_back(fresh);
    end
    mismatches <= fail_total;
    awaited    <= token_queue.size();
  end

endmodule

// ----- tb/sv/word_token_classifier_tb.sv -----
// word_token_classifier_tb: clock, reset, character stimulus, terminator mask settings
// and the final verdict; checking is left to word_token_classifier_checker
// depends on wtc_pkg, wtc_if, word_token_classifier and word_token_classifier_checker
module word_token_classifier_tb;
  import wtc_pkg::*;

  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int SETTLE_CYCLES     = 8;
  localparam int ITEMS_PER_SETTING = 110;

  typedef enum int {
    MASK_CLEAR, MASK_FULL, MASK_SOURCE, MASK_RANDOM, MASK_SOURCE_NO_DOT
  } mask_kind_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles  = 0;
  int chars_sent    = 0;
  int mismatches;
  int awaited;

  // stimulus-side copy of the masks, used only to shape the character stream
  logic [CFG_DATA_W-1:0] mask_lo = '0;
  logic [CFG_DATA_W-1:0] mask_hi = '0;
  logic [POS_W-1:0]      next_pos = '0;
  logic [CHAR_W-1:0]     spell [$];

  wtc_in_if  in_if ();
  wtc_out_if out_if ();
  wtc_cfg_if cfg_if ();

  word_token_classifier DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  word_token_classifier_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_mon    (cfg_if),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("word_token_classifier: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic ends_token(input logic [CHAR_W-1:0] c);
    if (c < 64) return mask_lo[c[5:0]];
    if (c < 128) return mask_hi[c[5:0]];
    return 1'b0;
  endfunction

  // a terminator inside a word would cut it short, so move it to the upper half
  function automatic logic [CHAR_W-1:0] word_safe(input logic [CHAR_W-1:0] c);
    return (c == CHAR_NUL || ends_token(c)) ? (c | 8'h80) : c;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_terminator();
    logic [CHAR_W-1:0] c;
    for (int t = 0; t < 64; t++) begin
      c = CHAR_W'($urandom_range(1, 127));
      if (ends_token(c)) return c;
    end
    return CHAR_NUL;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_letter();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return CHAR_W'($urandom_range(128, 255));
    if (pick == 1) return "_";
    if (pick < 8) return CHAR_W'("A" + $urandom_range(0, 25));
    return CHAR_W'("a" + $urandom_range(0, 25));
  endfunction

  function automatic logic [CHAR_W-1:0] rand_digit();
    return CHAR_W'(CHAR_ZERO + $urandom_range(0, 9));
  endfunction

  // table text is right-aligned, first character in the highest used byte
  function automatic void spell_text(input logic [TEXT_W-1:0] text, input int len);
    for (int i = len - 1; i >= 0; i--) spell.push_back(text[8*i +: 8]);
  endfunction

  task automatic put_char(input logic [CHAR_W-1:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.character <= c;
    in_if.position  <= next_pos;
    do @(posedge clk); while (!in_if.ready);
    next_pos++;
    chars_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  // hold the sender until every predicted token has come out
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
  endtask

  task automatic set_terminators(input mask_kind_t kind);
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [CHAR_W-1:0]     m;
    string                 marks;
    lo = '0;
    hi = '0;
    case (kind)
      MASK_FULL: begin
        lo = '1;
        hi = '1;
      end
      MASK_SOURCE, MASK_SOURCE_NO_DOT: begin
        marks = " \t\n\r;,()+-*=<>{}[]";
        if (kind == MASK_SOURCE) marks = {marks, "."};
        for (int i = 0; i < marks.len(); i++) begin
          m = marks[i];
          if (m < 64) lo[m[5:0]] = 1'b1;
          else hi[m[5:0]] = 1'b1;
        end
      end
      MASK_RANDOM: begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
      end
      default: ;
    endcase
    // a nul always leaves the scanner between tokens; drain before writing
    put_char(CHAR_NUL);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_if.valid <= 1'b1;
    for (int r = 0; r < 2; r++) begin
      cfg_if.reg_index <= (r == 0) ? REG_TERM_LOW : REG_TERM_HIGH;
      cfg_if.wdata     <= (r == 0) ? lo : hi;
      do @(posedge clk); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
    mask_lo = lo;
    mask_hi = hi;
  endtask

  // one token followed by its ending character, usually presented twice
  task automatic send_token();
    int                pick;
    int                n;
    int                idx;
    logic [CHAR_W-1:0] term;
    spell.delete();
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      idx = $urandom_range(0, NUM_KEYWORDS + NUM_TYPES + 1);
      if (idx < NUM_KEYWORDS) spell_text(KW_TEXT[idx], KW_LEN[idx]);
      else if (idx < NUM_KEYWORDS + NUM_TYPES)
        spell_text(TY_TEXT[idx - NUM_KEYWORDS], TY_LEN[idx - NUM_KEYWORDS]);
      else if (idx == NUM_KEYWORDS + NUM_TYPES) spell_text(TRUE_TEXT, TRUE_LEN);
      else spell_text(FALSE_TEXT, FALSE_LEN);
      // near misses: one letter more, one less, or one changed
      case ($urandom_range(0, 9))
        0: spell.push_back(word_safe(rand_letter()));
        1: if (spell.size() > 1) spell.delete(spell.size() - 1);
        2: spell[$urandom_range(0, spell.size() - 1)] = word_safe(rand_letter());
        default: ;
      endcase
    end else if (pick < 45) begin
      // identifiers, a few past the word buffer
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 14);
      spell.push_back(word_safe(rand_letter()));
      while (spell.size() < n)
        spell.push_back(word_safe(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter()));
    end else if (pick < 75) begin
      n = $urandom_range(1, 8);
      repeat (n) spell.push_back(rand_digit());
      if ($urandom_range(0, 1)) begin
        spell.push_back(CHAR_DOT);
        n = $urandom_range(0, 6);  // none leaves the dot last
        repeat (n) spell.push_back(rand_digit());
      end
      // broken numbers: a stray dot or letter after the first digit
      if ($urandom_range(0, 6) == 0)
        spell.insert($urandom_range(1, spell.size()),
                     $urandom_range(0, 1) ? CHAR_DOT : rand_letter());
    end else begin
      // noise
      n = $urandom_range(1, 6);
      repeat (n) spell.push_back(CHAR_W'($urandom_range(1, 255)));
    end
    foreach (spell[i]) put_char(spell[i]);
    term = ($urandom_range(0, 7) == 0) ? CHAR_NUL : pick_terminator();
    put_char(term);
    if ($urandom_range(0, 4) != 0) put_char(term);
  endtask

  task automatic run_stream(input int count);
    int stop_at;
    stop_at = chars_sent + count;
    while (chars_sent < stop_at) begin
      case ($urandom_range(0, 39))
        0: next_pos = $urandom();
        1: next_pos = '1 - $urandom_range(0, 4);
        2: wait_drained();
        default: ;
      endcase
      send_token();
    end
  endtask

  initial begin
    in_if.valid      <= 1'b0;
    in_if.character  <= '0;
    in_if.position   <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.reg_index <= REG_TERM_LOW;
    cfg_if.wdata     <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: end of file, empty tokens, floats, bad numbers, booleans
    set_terminators(MASK_SOURCE);
    next_pos = '0;
    put_char(CHAR_NUL);
    next_pos = 32'hFFFF_FFFE;
    send_string("12.5  ");
    send_string("1.2.3");
    put_char(CHAR_NUL);
    put_char(CHAR_NUL);
    send_string("7.  ");
    send_string("true..");
    send_string("9a");
    put_char(CHAR_NUL);

    // random streams over every mask setting and idling pattern
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 67 : 0;
      recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 19 : 0;
      for (int k = 0; k < 5; k++) begin
        set_terminators(mask_kind_t'(k));
        run_stream(ITEMS_PER_SETTING);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("word_token_classifier: match");
    end else begin
      $display("word_token_classifier: mismatch");
    end
    $finish;
  end

endmodule

// ----- word_token_classifier.f -----
sv/wtc_pkg.sv
sv/wtc_if.sv
sv/wtc_front.sv
sv/wtc_queue.sv
sv/wtc_back.sv
sv/word_token_classifier.sv
sv/wtc_checker.sv
tb/sv/word_token_classifier_checker.sv
tb/sv/word_token_classifier_tb.sv
